FILE: hdl/ppm_pkg.sv
// Package for the four-channel pulse period meter.
// Holds request and result types, lane control types and fixed constants; no dependencies.
package ppm_pkg;

  typedef enum logic [1:0] {
    CmdEdge = 2'd0,
    CmdTick = 2'd1,
    CmdRead = 2'd2
  } cmd_e;

  localparam logic RegMaxPeriod = 1'b0;
  localparam logic RegMinPeriod = 1'b1;

  localparam logic [15:0] MaxPeriodReset = 16'd32768;
  localparam logic [15:0] MinPeriodReset = 16'd39;
  localparam logic [7:0]  CountSat       = 8'hFF;
  localparam logic [7:0]  CountAfterSat  = 8'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  channel;
    logic [15:0] timestamp;
  } req_t;

  typedef struct packed {
    logic [15:0] period;
    logic [1:0]  read_channel;
    logic        stalled;
  } res_t;

  typedef struct packed {
    logic        edge_hit;
    logic        tick;
    logic        read_hit;
    logic [15:0] timestamp;
  } lane_ctrl_t;

  typedef struct packed {
    logic [15:0] period;
    logic        stalled;
  } lane_stat_t;

endpackage

FILE: hdl/four_channel_pulse_period_meter.sv
// Top level of the pulse period meter: request register, channel lanes, result register, APB.
// Depends on ppm_pkg and ppm_lane.
// A read goes from the request register to the result register, where its result is held.
// Throughput: one request per cycle unless stalled; edge and tick requests give no result.
// A stalled result register stalls only requests behind a read waiting for it.
// Reset (asynchronous, active low): clear channel state, set stall marks, load 32768 and 39.
module four_channel_pulse_period_meter #(
  parameter int CHANNELS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ppm_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ppm_pkg::res_t out_res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic          req_valid_q;
  ppm_pkg::req_t req_q;
  logic          out_valid_q;
  ppm_pkg::res_t res_q;
  logic [15:0]   max_period_q;
  logic [15:0]   min_period_q;
  logic          is_read;
  logic          advance;
  logic          cfg_write;
  ppm_pkg::res_t res_d;

  ppm_pkg::lane_stat_t lane_stat [CHANNELS];

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_period_q <= ppm_pkg::MaxPeriodReset;
      min_period_q <= ppm_pkg::MinPeriodReset;
    end else if (cfg_write) begin
      if (paddr[2] == ppm_pkg::RegMaxPeriod) begin
        max_period_q <= pwdata[15:0];
      end else begin
        min_period_q <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == ppm_pkg::RegMaxPeriod) ? {16'd0, max_period_q}
                                                      : {16'd0, min_period_q};

  assign is_read    = (req_q.command == ppm_pkg::CmdRead);
  assign advance    = req_valid_q && (!is_read || !out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    ppm_pkg::lane_ctrl_t ctrl;
    logic                hit;

    assign hit            = (int'(req_q.channel) == i);
    assign ctrl.edge_hit  = advance && hit && (req_q.command == ppm_pkg::CmdEdge);
    assign ctrl.tick      = advance && (req_q.command == ppm_pkg::CmdTick);
    assign ctrl.read_hit  = advance && hit && is_read;
    assign ctrl.timestamp = req_q.timestamp;

    ppm_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .max_period_i (max_period_q),
      .min_period_i (min_period_q),
      .stat_o       (lane_stat[i])
    );
  end

  always_comb begin
    res_d              = '0;
    res_d.read_channel = req_q.channel;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(req_q.channel) == i) begin
        res_d.period  = lane_stat[i].period;
        res_d.stalled = lane_stat[i].stalled;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_read) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_read) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

FILE: hdl/ppm_lane.sv
// One channel of the pulse period meter: capture, edge count, stall mark and last period.
// Depends on ppm_pkg for the lane control and status types.
module ppm_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppm_pkg::lane_ctrl_t ctrl_i,
  input  logic [15:0]         max_period_i,
  input  logic [15:0]         min_period_i,
  output ppm_pkg::lane_stat_t stat_o
);

  logic [15:0] latest_q, latest_d;
  logic [15:0] held_q, held_d;
  logic        fresh_q, fresh_d;
  logic [7:0]  count_q, count_d;
  logic        stall_q, stall_d;
  logic [15:0] last_q, last_d;
  logic [15:0] diff;
  logic [15:0] clamped;
  logic [15:0] period;
  logic        sat;

  assign diff = latest_q - held_q;
  assign sat  = (count_q == ppm_pkg::CountSat);

  always_comb begin
    clamped = diff;
    if (clamped > max_period_i) begin
      clamped = max_period_i;
    end
    if (clamped < min_period_i) begin
      clamped = min_period_i;
    end
  end

  always_comb begin
    if (stall_q) begin
      period = max_period_i;
    end else if (!fresh_q || sat) begin
      period = last_q;
    end else if (latest_q == held_q || latest_q == 16'd0 || held_q == 16'd0) begin
      period = last_q;
    end else begin
      period = clamped;
    end
  end

  assign stat_o.period  = period;
  assign stat_o.stalled = stall_q;

  always_comb begin
    latest_d = latest_q;
    held_d   = held_q;
    fresh_d  = fresh_q;
    count_d  = count_q;
    stall_d  = stall_q;
    last_d   = last_q;
    if (ctrl_i.edge_hit) begin
      held_d   = latest_q;
      latest_d = ctrl_i.timestamp;
      fresh_d  = 1'b1;
      if (!sat) begin
        count_d = count_q + 8'd1;
      end
    end
    if (ctrl_i.tick) begin
      stall_d = (count_q <= 8'd1);
      count_d = 8'd0;
    end
    if (ctrl_i.read_hit) begin
      last_d = period;
      if (!stall_q && fresh_q) begin
        fresh_d = 1'b0;
        if (sat) begin
          count_d = ppm_pkg::CountAfterSat;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q <= '0;
      held_q   <= '0;
      fresh_q  <= 1'b0;
      count_q  <= '0;
      stall_q  <= 1'b1;
      last_q   <= '0;
    end else begin
      latest_q <= latest_d;
      held_q   <= held_d;
      fresh_q  <= fresh_d;
      count_q  <= count_d;
      stall_q  <= stall_d;
      last_q   <= last_d;
    end
  end

endmodule

FILE: hdl/ppm_checker.sv
// Port-level checks for the pulse period meter, bound to the top level.
// Depends on ppm_pkg; sees the top-level ports only.
module ppm_port_checks (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ppm_pkg::res_t out_res_o,
  input logic          psel,
  input logic          penable,
  input logic          pwrite,
  input logic [2:0]    paddr,
  input logic [31:0]   pwdata,
  input logic [31:0]   prdata,
  input logic          pready
);

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
  else $error("pready dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
  else $error("stalled result changed");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
  else $error("request refused while result side is free");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr == 3'd0 ##1 psel && !pwrite && paddr == 3'd0
    |-> prdata[15:0] == $past(pwdata[15:0]))
  else $error("max_period readback mismatch");

  a_prdata_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[31:16] == 16'd0)
  else $error("register read sets unused bits");

endmodule

bind four_channel_pulse_period_meter ppm_port_checks u_ppm_port_checks (.*);

FILE: dv/ppm_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the pulse period meter: follows requests and register writes, predicts
// every read result and compares it field by field with the block's output. Needs ppm_pkg.
module ppm_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  ppm_pkg::req_t in_req_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  ppm_pkg::res_t out_res_i,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic          pready_i,
  input  logic [2:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  output int            pending_o,
  output int            errors_o
);

  localparam int Lanes = 4;

  logic [15:0]   max_period;
  logic [15:0]   min_period;
  logic [15:0]   newest_stamp [Lanes];
  logic [15:0]   older_stamp [Lanes];
  logic          fresh [Lanes];
  logic [7:0]    edges_seen [Lanes];
  logic          stall_flag [Lanes];
  logic [15:0]   reported [Lanes];
  ppm_pkg::res_t readings_due [$];
  ppm_pkg::res_t want;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors_o++;
  endtask

  task automatic clear_meter();
    max_period = ppm_pkg::MaxPeriodReset;
    min_period = ppm_pkg::MinPeriodReset;
    for (int i = 0; i < Lanes; i++) begin
      newest_stamp[i] = '0;
      older_stamp[i]  = '0;
      fresh[i]        = 1'b0;
      edges_seen[i]   = '0;
      stall_flag[i]   = 1'b1;
      reported[i]     = '0;
    end
    readings_due.delete();
  endtask

  task automatic track_request(input ppm_pkg::req_t r);
    logic [15:0]   span;
    logic [15:0]   value;
    ppm_pkg::res_t reading;
    int            c;
    c = r.channel;
    case (r.command)
      ppm_pkg::CmdEdge: begin
        older_stamp[c]  = newest_stamp[c];
        newest_stamp[c] = r.timestamp;
        fresh[c]        = 1'b1;
        if (edges_seen[c] != ppm_pkg::CountSat) edges_seen[c] = edges_seen[c] + 8'd1;
      end
      ppm_pkg::CmdTick: begin
        for (int i = 0; i < Lanes; i++) begin
          stall_flag[i] = (edges_seen[i] <= 8'd1);
          edges_seen[i] = '0;
        end
      end
      ppm_pkg::CmdRead: begin
        if (stall_flag[c]) begin
          value = max_period;
        end else if (!fresh[c]) begin
          value = reported[c];
        end else begin
          fresh[c] = 1'b0;
          span     = newest_stamp[c] - older_stamp[c];
          if (edges_seen[c] == ppm_pkg::CountSat) begin
            edges_seen[c] = ppm_pkg::CountAfterSat;
            value         = reported[c];
          end else if (span == '0 || newest_stamp[c] == '0 || older_stamp[c] == '0) begin
            value = reported[c];
          end else begin
            value = (span > max_period) ? max_period : span;
            if (value < min_period) value = min_period;
          end
        end
        reported[c]          = value;
        reading.period       = value;
        reading.read_channel = r.channel;
        reading.stalled      = stall_flag[c];
        readings_due.push_back(reading);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_meter();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (readings_due.size() == 0) begin
          report_mismatch($sformatf("result for channel %0d with none outstanding",
                                    out_res_i.read_channel));
        end else begin
          want = readings_due.pop_front();
          if (out_res_i.period !== want.period)
            report_mismatch($sformatf("channel %0d period %0d, predicted %0d",
                                      want.read_channel, out_res_i.period, want.period));
          if (out_res_i.read_channel !== want.read_channel)
            report_mismatch($sformatf("read_channel %0d, predicted %0d",
                                      out_res_i.read_channel, want.read_channel));
          if (out_res_i.stalled !== want.stalled)
            report_mismatch($sformatf("channel %0d stalled %0b, predicted %0b",
                                      want.read_channel, out_res_i.stalled, want.stalled));
        end
      end
      if (in_valid_i && in_ready_i) track_request(in_req_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == {ppm_pkg::RegMaxPeriod, 2'b00}) max_period = pwdata_i[15:0];
        else if (paddr_i == {ppm_pkg::RegMinPeriod, 2'b00}) min_period = pwdata_i[15:0];
      end
      pending_o <= readings_due.size();
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the pulse period meter: clock, reset, requests, register writes, verdict.
// Needs ppm_pkg, four_channel_pulse_period_meter and ppm_checker.
module tb;

  localparam int          CycleLimit = 400000;
  localparam int          PhaseItems = 240;
  localparam logic [1:0]  CmdUnused  = 2'd3;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  ppm_pkg::req_t in_req    = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  ppm_pkg::res_t out_res;
  logic          psel      = 1'b0;
  logic          penable   = 1'b0;
  logic          pwrite    = 1'b0;
  logic [2:0]    paddr     = '0;
  logic [31:0]   pwdata    = '0;
  logic [31:0]   prdata;
  logic          pready;
  int            pending;
  int            errors;
  int            cycles     = 0;
  int            send_idle  = 0;
  int            recv_stall = 0;
  logic [15:0]   stamp_of [4];

  four_channel_pulse_period_meter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  ppm_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_res_i   (out_res),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[four_channel_pulse_period_meter] ERROR");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall);

  function automatic ppm_pkg::req_t rq(input logic [1:0] cmd, input logic [1:0] ch,
                                       input logic [15:0] ts);
    rq = '{command: cmd, channel: ch, timestamp: ts};
  endfunction

  task automatic send(input ppm_pkg::req_t r);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic capture(input logic [1:0] ch);
    int          pick;
    logic [15:0] ts;
    pick = $urandom_range(0, 99);
    if (pick < 4) ts = '0;
    else if (pick < 8) ts = stamp_of[ch];
    else if (pick < 22) ts = stamp_of[ch] + 16'($urandom_range(1, 60));
    else if (pick < 32) ts = 16'($urandom);
    else ts = stamp_of[ch] + 16'($urandom_range(61, 4000));
    stamp_of[ch] = ts;
    send(rq(ppm_pkg::CmdEdge, ch, ts));
  endtask

  task automatic random_request();
    int         pick;
    logic [1:0] ch;
    pick = $urandom_range(0, 99);
    ch   = 2'($urandom_range(0, 3));
    if (pick < 50) capture(ch);
    else if (pick < 88) send(rq(ppm_pkg::CmdRead, ch, 16'($urandom)));
    else if (pick < 97) send(rq(ppm_pkg::CmdTick, ch, 16'($urandom)));
    else send(rq(CmdUnused, ch, 16'($urandom)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] max_p, input logic [15:0] min_p,
                           input int idle, input int stall);
    drain();
    write_reg({ppm_pkg::RegMaxPeriod, 2'b00}, max_p);
    write_reg({ppm_pkg::RegMinPeriod, 2'b00}, min_p);
    send_idle  = idle;
    recv_stall = stall;
    repeat (PhaseItems) random_request();
  endtask

  initial begin
    for (int i = 0; i < 4; i++) stamp_of[i] = 16'd1000 * 16'(i + 1);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(rq(ppm_pkg::CmdRead, 2'd0, 16'h0000));
    send(rq(ppm_pkg::CmdEdge, 2'd1, 16'h0000));
    send(rq(ppm_pkg::CmdEdge, 2'd1, 16'hFFFF));
    send(rq(ppm_pkg::CmdEdge, 2'd0, 16'd100));
    send(rq(ppm_pkg::CmdEdge, 2'd0, 16'd50));
    send(rq(ppm_pkg::CmdTick, 2'd3, 16'hFFFF));
    send(rq(ppm_pkg::CmdRead, 2'd0, 16'h0000));
    send(rq(ppm_pkg::CmdRead, 2'd1, 16'h0000));
    send(rq(ppm_pkg::CmdRead, 2'd0, 16'h0000));
    send(rq(ppm_pkg::CmdEdge, 2'd2, 16'd1000));
    send(rq(ppm_pkg::CmdEdge, 2'd2, 16'd1000));
    send(rq(ppm_pkg::CmdEdge, 2'd3, 16'd500));
    send(rq(ppm_pkg::CmdEdge, 2'd3, 16'd510));
    send(rq(ppm_pkg::CmdTick, 2'd0, 16'h0000));
    send(rq(ppm_pkg::CmdRead, 2'd2, 16'h0000));
    send(rq(ppm_pkg::CmdRead, 2'd3, 16'h0000));
    send(rq(CmdUnused, 2'd1, 16'hAAAA));
    send(rq(ppm_pkg::CmdEdge, 2'd0, 16'h5555));
    send(rq(ppm_pkg::CmdTick, 2'd2, 16'h0000));
    send(rq(ppm_pkg::CmdRead, 2'd0, 16'h0000));
    send(rq(ppm_pkg::CmdRead, 2'd3, 16'hFFFF));
    repeat (PhaseItems) random_request();

    run_phase(16'hFFFF, 16'd1, 56, 0);
    // hold one channel busy long enough to saturate its edge count
    capture(2'd1);
    capture(2'd1);
    send(rq(ppm_pkg::CmdTick, 2'd1, 16'h0000));
    repeat (260) capture(2'd1);
    send(rq(ppm_pkg::CmdRead, 2'd1, 16'h0000));
    capture(2'd1);
    capture(2'd1);
    send(rq(ppm_pkg::CmdRead, 2'd1, 16'h0000));

    run_phase(16'd1, 16'hFFFF, 0, 56);
    run_phase(16'd200, 16'd40, 20, 20);
    run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 0, 0);

    drain();
    if (errors == 0) begin
      $display("[four_channel_pulse_period_meter] OK");
    end else begin
      $display("[four_channel_pulse_period_meter] ERROR");
    end
    $finish;
  end

endmodule

FILE: four_channel_pulse_period_meter.f
hdl/ppm_pkg.sv
hdl/ppm_lane.sv
hdl/four_channel_pulse_period_meter.sv
hdl/ppm_checker.sv
dv/ppm_checker.sv
dv/tb.sv
